/* src/pcdf_pkg.sv */
// Shared types and constants for the PMT component descriptor finder.
// No dependencies; every other file in src imports this package.
package pcdf_pkg;

  // Field widths of the section tracking registers
  localparam int unsigned POS_W  = 13;
  localparam int unsigned TOT_W  = 13;
  localparam int unsigned PIL_W  = 12;
  localparam int unsigned ESL_W  = 14;
  localparam int unsigned EDL_W  = 12;
  localparam int unsigned PID_W  = 13;
  localparam int unsigned DIDX_W = 3;

  // Decoupling queue between front and back (power of two)
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);

  // Header byte positions
  localparam logic [POS_W-1:0] POS_LEN_HI = 13'd1;
  localparam logic [POS_W-1:0] POS_LEN_LO = 13'd2;
  localparam logic [POS_W-1:0] POS_PIL_HI = 13'd10;
  localparam logic [POS_W-1:0] POS_PIL_LO = 13'd11;

  // Section framing: bytes ahead of the stream loop and the length trailer
  localparam logic [ESL_W-1:0] FIXED_OVERHEAD = 14'd16;
  localparam logic [TOT_W-1:0] LEN_TRAILER    = 13'd3;
  localparam logic [ESL_W-1:0] ES_HEAD_MIN    = 14'd5;
  localparam logic [7:0]       DESC_LEN_MIN   = 8'd5;

  // Masks
  localparam logic [7:0] LEN_HI_MASK    = 8'h0f;
  localparam logic [7:0] PID_HI_MASK    = 8'h1f;
  localparam logic [7:0] DESC_FLAG_MASK = 8'h80;

  // Descriptor body signature "TKGS"
  localparam logic [7:0] SIGNATURE [4] = '{8'h54, 8'h4b, 8'h47, 8'h53};

  // Descriptor byte index landmarks
  localparam logic [DIDX_W-1:0] DI_TAG  = 3'd0;
  localparam logic [DIDX_W-1:0] DI_LEN  = 3'd1;
  localparam logic [DIDX_W-1:0] DI_SIG0 = 3'd2;
  localparam logic [DIDX_W-1:0] DI_SIG3 = 3'd5;
  localparam logic [DIDX_W-1:0] DI_FLAG = 3'd6;
  localparam logic [DIDX_W-1:0] DI_SAT  = 3'd7;

  // Stream entry header byte index
  localparam logic [2:0] EH_PID_HI = 3'd1;
  localparam logic [2:0] EH_PID_LO = 3'd2;
  localparam logic [2:0] EH_EDL_HI = 3'd3;
  localparam logic [2:0] EH_EDL_LO = 3'd4;

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_HEADER = 6'b000010,
    PH_PROG   = 6'b000100,
    PH_ESHEAD = 6'b001000,
    PH_ESDESC = 6'b010000,
    PH_SKIP   = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       section_start;
  } item_t;

  typedef struct packed {
    logic             found;
    logic             pid_valid;
    logic [PID_W-1:0] stream_pid_out;
  } result_t;

endpackage

/* src/pcdf_ifs.sv */
// Valid/ready channel interfaces for section bytes, results and the tag register.
// Depends on pcdf_pkg for field widths.
interface pcdf_item_if;
  import pcdf_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       section_start;
  modport source (output valid, output data_byte, output section_start, input ready);
  modport sink   (input valid, input data_byte, input section_start, output ready);
endinterface

interface pcdf_result_if;
  import pcdf_pkg::*;
  logic             valid;
  logic             ready;
  logic             found;
  logic             pid_valid;
  logic [PID_W-1:0] stream_pid_out;
  modport source (output valid, output found, output pid_valid, output stream_pid_out,
                  input ready);
  modport sink   (input valid, input found, input pid_valid, input stream_pid_out,
                  output ready);
endinterface

interface pcdf_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] component_tag;
  modport source (output valid, output component_tag, input ready);
  modport sink   (input valid, input component_tag, output ready);
endinterface

/* src/pmt_component_descriptor_finder_core.sv */
// PMT component descriptor finder: byte intake, queue and section parser.
// Throughput: one section byte per cycle, sustained while results are taken.
// Result path: the final section byte is written into the queue, then parsed out of the queue
// into the result register; a held result adds its stall.
// Reset: synchronous, active high; parser idles awaiting a section start, tag resets to 0.
// Depends on pcdf_pkg, pcdf_ifs, pcdf_queue and pcdf_parser.
module pmt_component_descriptor_finder_core
  import pcdf_pkg::*;
(
  input logic           clk,
  input logic           rst,
  pcdf_item_if.sink     item,
  pcdf_result_if.source result,
  pcdf_cfg_if.sink      cfg
);

  logic [7:0] component_tag;
  item_t      in_item;
  item_t      q_head;
  logic       q_not_full;
  logic       q_not_empty;
  logic       q_pop;
  logic       res_valid;
  result_t    res_data;

  // tag register, always writable
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      component_tag <= '0;
    end else if (cfg.valid) begin
      component_tag <= cfg.component_tag;
    end
  end

  // front: bundle the incoming beat
  assign in_item.data_byte     = item.data_byte;
  assign in_item.section_start = item.section_start;
  assign item.ready            = q_not_full;

  pcdf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (item.valid),
    .push_item (in_item),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // back: section parser with result register
  pcdf_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .component_tag (component_tag),
    .q_valid       (q_not_empty),
    .q_item        (q_head),
    .pop           (q_pop),
    .res_valid     (res_valid),
    .res_ready     (result.ready),
    .res_data      (res_data)
  );

  assign result.valid          = res_valid;
  assign result.found          = res_data.found;
  assign result.pid_valid      = res_data.pid_valid;
  assign result.stream_pid_out = res_data.stream_pid_out;

endmodule

/* src/pcdf_queue.sv */
// Short FIFO between the byte intake and the section parser.
// Depends on pcdf_pkg (item_t, Q_DEPTH).
module pcdf_queue
  import pcdf_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  not_full,
  input  logic  pop,
  output logic  not_empty,
  output item_t head
);

  item_t              mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_PTR_W:0]   count;
  logic               do_push;
  logic               do_pop;

  assign not_full  = (count != Q_DEPTH[Q_PTR_W:0]);
  assign not_empty = (count != '0);
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign head      = mem[rd_ptr];

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // pointers wrap by overflow since the depth is a power of two
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* src/pcdf_parser.sv */
// Section parser: walks the PMT header and both descriptor loops, one byte a cycle while the result slot is free.
// Depends on pcdf_pkg; fed by pcdf_queue, drives a one-deep result register.
module pcdf_parser
  import pcdf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] component_tag,
  input  logic       q_valid,
  input  item_t      q_item,
  output logic       pop,
  output logic       res_valid,
  input  logic       res_ready,
  output result_t    res_data
);

  typedef struct packed {
    phase_t            phase;
    logic [POS_W-1:0]  byte_position;
    logic [TOT_W-1:0]  section_total;
    logic [PIL_W-1:0]  program_info_left;
    logic [ESL_W-1:0]  es_loop_left;
    logic [2:0]        es_header_index;
    logic [PID_W-1:0]  current_es_pid;
    logic [EDL_W-1:0]  es_desc_left;
    logic [DIDX_W-1:0] desc_byte_index;
    logic [7:0]        desc_length;
    logic              desc_match;
    logic              found_flag;
    logic              pid_hit;
    logic [PID_W-1:0]  hit_pid;
  } parse_t;

  typedef struct packed {
    logic [DIDX_W-1:0] idx;
    logic [7:0]        len;
    logic              match;
    logic              hit;
  } desc_t;

  // One byte of a descriptor loop; left counts loop bytes including this one
  function automatic desc_t desc_step(input logic [DIDX_W-1:0] idx,
                                      input logic [7:0] len,
                                      input logic match,
                                      input logic [7:0] tag,
                                      input logic [7:0] b,
                                      input logic [PIL_W-1:0] left);
    desc_t      r;
    logic [1:0] sel;
    r.idx   = idx;
    r.len   = len;
    r.match = match;
    r.hit   = 1'b0;
    sel     = idx[1:0] - 2'd2;
    if (idx == DI_TAG) begin
      r.match = (b == tag);
      r.idx   = DI_LEN;
    end else if (idx == DI_LEN) begin
      r.len = b;
      if ((b < DESC_LEN_MIN) || (({5'b0, b} + 13'd1) > {1'b0, left})) begin
        r.match = 1'b0;
      end
      r.idx = (b != 8'd0) ? DI_SIG0 : DI_TAG;
    end else begin
      if ((idx >= DI_SIG0) && (idx <= DI_SIG3)) begin
        if (b != SIGNATURE[sel]) begin
          r.match = 1'b0;
        end
      end else if (idx == DI_FLAG) begin
        if ((b & DESC_FLAG_MASK) != 8'd0) begin
          r.hit = match;
        end
        r.match = 1'b0;
      end
      r.len = len - 8'd1;
      if (r.len == 8'd0) begin
        r.idx = DI_TAG;
      end else if (idx < DI_SAT) begin
        r.idx = idx + 3'd1;
      end
    end
    return r;
  endfunction

  // Next phase on entering the stream loop
  function automatic phase_t es_phase(input logic [ESL_W-1:0] es_left);
    return (es_left > ES_HEAD_MIN) ? PH_ESHEAD : PH_SKIP;
  endfunction

  parse_t           parse_st;
  parse_t           parse_st_next;
  parse_t           work;
  desc_t            d;
  logic             emit;
  logic [7:0]       b;
  logic [ESL_W-1:0] tot_ext;
  logic [ESL_W-1:0] need;
  logic [PIL_W-1:0] pil;
  logic [EDL_W-1:0] edl;
  result_t          res_next;

  // take a byte whenever the result slot is free or draining
  assign pop = q_valid && (!res_valid || res_ready);
  assign b   = q_item.data_byte;

  // byte-level parse step
  always_comb begin
    work          = parse_st;
    d             = '0;
    emit          = 1'b0;
    tot_ext       = '0;
    need          = '0;
    pil           = '0;
    edl           = '0;
    if (q_item.section_start) begin
      work       = '0;
      work.phase = PH_HEADER;
    end
    parse_st_next = work;

    if (work.phase != PH_IDLE) begin
      unique case (work.phase)
        PH_HEADER: begin
          if (work.byte_position == POS_LEN_HI) begin
            parse_st_next.section_total = {5'b0, b & LEN_HI_MASK};
          end else if (work.byte_position == POS_LEN_LO) begin
            parse_st_next.section_total = {work.section_total[4:0], b} + LEN_TRAILER;
          end else if (work.byte_position == POS_PIL_HI) begin
            parse_st_next.program_info_left = {b[3:0] & LEN_HI_MASK[3:0], 8'h00};
          end else if (work.byte_position == POS_PIL_LO) begin
            pil     = {work.program_info_left[11:8], b};
            tot_ext = {1'b0, work.section_total};
            need    = FIXED_OVERHEAD + {2'b0, pil};
            parse_st_next.program_info_left = pil;
            parse_st_next.es_loop_left      = (tot_ext >= need) ? (tot_ext - need) : '0;
            parse_st_next.desc_byte_index   = DI_TAG;
            if (pil != '0) begin
              parse_st_next.phase = PH_PROG;
            end else begin
              parse_st_next.es_header_index = '0;
              parse_st_next.phase = es_phase(parse_st_next.es_loop_left);
            end
          end
        end
        PH_PROG: begin
          d = desc_step(work.desc_byte_index, work.desc_length, work.desc_match,
                        component_tag, b, work.program_info_left);
          parse_st_next.desc_byte_index = d.idx;
          parse_st_next.desc_length     = d.len;
          parse_st_next.desc_match      = d.match;
          if (d.hit) begin
            parse_st_next.found_flag = 1'b1;
          end
          parse_st_next.program_info_left = work.program_info_left - 1'b1;
          if (parse_st_next.program_info_left == '0) begin
            parse_st_next.es_header_index = '0;
            parse_st_next.phase = es_phase(work.es_loop_left);
          end
        end
        PH_ESHEAD: begin
          parse_st_next.es_loop_left = work.es_loop_left - 1'b1;
          if (work.es_header_index == EH_PID_HI) begin
            parse_st_next.current_es_pid = {b[4:0] & PID_HI_MASK[4:0], 8'h00};
          end else if (work.es_header_index == EH_PID_LO) begin
            parse_st_next.current_es_pid = {work.current_es_pid[12:8], b};
          end else if (work.es_header_index == EH_EDL_HI) begin
            parse_st_next.es_desc_left = {b[3:0] & LEN_HI_MASK[3:0], 8'h00};
          end else if (work.es_header_index == EH_EDL_LO) begin
            edl = {work.es_desc_left[11:8], b};
            if ({2'b0, edl} > parse_st_next.es_loop_left) begin
              edl = parse_st_next.es_loop_left[EDL_W-1:0];
            end
            parse_st_next.es_desc_left = edl;
          end
          if (work.es_header_index < EH_EDL_LO) begin
            parse_st_next.es_header_index = work.es_header_index + 3'd1;
          end else begin
            parse_st_next.desc_byte_index = DI_TAG;
            if (parse_st_next.es_desc_left != '0) begin
              parse_st_next.phase = PH_ESDESC;
            end else begin
              parse_st_next.es_header_index = '0;
              parse_st_next.phase = es_phase(parse_st_next.es_loop_left);
            end
          end
        end
        PH_ESDESC: begin
          parse_st_next.es_loop_left = work.es_loop_left - 1'b1;
          d = desc_step(work.desc_byte_index, work.desc_length, work.desc_match,
                        component_tag, b, work.es_desc_left);
          parse_st_next.desc_byte_index = d.idx;
          parse_st_next.desc_length     = d.len;
          parse_st_next.desc_match      = d.match;
          if (d.hit) begin
            parse_st_next.found_flag = 1'b1;
            parse_st_next.pid_hit    = 1'b1;
            parse_st_next.hit_pid    = work.current_es_pid;
            parse_st_next.phase      = PH_SKIP;
          end else begin
            parse_st_next.es_desc_left = work.es_desc_left - 1'b1;
            if (parse_st_next.es_desc_left == '0) begin
              parse_st_next.es_header_index = '0;
              parse_st_next.phase = es_phase(parse_st_next.es_loop_left);
            end
          end
        end
        PH_IDLE, PH_SKIP: begin
        end
        default: begin
        end
      endcase

      // final section byte, CRC included
      parse_st_next.byte_position = work.byte_position + 1'b1;
      if ((work.byte_position >= POS_LEN_LO) &&
          (parse_st_next.byte_position == parse_st_next.section_total)) begin
        emit                = 1'b1;
        parse_st_next.phase = PH_IDLE;
      end
    end
  end

  // result fields
  always_comb begin
    res_next.found          = parse_st_next.found_flag;
    res_next.pid_valid      = parse_st_next.pid_hit;
    res_next.stream_pid_out = parse_st_next.pid_hit ? parse_st_next.hit_pid : '0;
  end

  // parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_st <= '{phase: PH_IDLE, default: '0};
    end else if (pop) begin
      parse_st <= parse_st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (pop) begin
      res_valid <= emit;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      res_data <= res_next;
    end
  end

endmodule
